// ===== rtl/core/iieu_pkg.sv =====
// ----------------------------------------------------------------------------
// iieu_pkg
// shared types and codes for the integer execute unit
// ----------------------------------------------------------------------------
package iieu_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_SYSCALL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_MD,
		FSM_WB,
		FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] instruction;
		logic [31:0] new_pc;
		logic [4:0]  probe_index;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] pc_after;
		logic        wrote_register;
		logic [4:0]  written_index;
		logic [31:0] written_value;
		logic [31:0] hi_value;
		logic [31:0] lo_value;
		logic [31:0] probe_value;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic is_div;
		logic sgn;
	} md_ctl_t;

	typedef struct packed {
		logic done;
		logic skip;
	} md_rsp_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] npc;
		logic        wr;
		logic [4:0]  widx;
		logic [31:0] wval;
		logic [31:0] hi;
		logic [31:0] lo;
		md_ctl_t     md;
	} res_t;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_REGIMM  = 6'd1;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_BLEZ    = 6'd6;
	localparam logic [5:0] OP_BGTZ    = 6'd7;
	localparam logic [5:0] OP_ADDI    = 6'd8;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTI    = 6'd10;
	localparam logic [5:0] OP_SLTIU   = 6'd11;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_XORI    = 6'd14;
	localparam logic [5:0] OP_LUI     = 6'd15;

	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_SRA     = 6'd3;
	localparam logic [5:0] FN_SLLV    = 6'd4;
	localparam logic [5:0] FN_SRLV    = 6'd6;
	localparam logic [5:0] FN_SRAV    = 6'd7;
	localparam logic [5:0] FN_JR      = 6'd8;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_MFHI    = 6'd16;
	localparam logic [5:0] FN_MTHI    = 6'd17;
	localparam logic [5:0] FN_MFLO    = 6'd18;
	localparam logic [5:0] FN_MTLO    = 6'd19;
	localparam logic [5:0] FN_MULT    = 6'd24;
	localparam logic [5:0] FN_MULTU   = 6'd25;
	localparam logic [5:0] FN_DIV     = 6'd26;
	localparam logic [5:0] FN_DIVU    = 6'd27;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_ADDU    = 6'd33;
	localparam logic [5:0] FN_SUB     = 6'd34;
	localparam logic [5:0] FN_SUBU    = 6'd35;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_XOR     = 6'd38;
	localparam logic [5:0] FN_NOR     = 6'd39;
	localparam logic [5:0] FN_SLT     = 6'd42;
	localparam logic [5:0] FN_SLTU    = 6'd43;

	localparam logic [4:0] RT_BLTZ    = 5'd0;
	localparam logic [4:0] RT_BGEZ    = 5'd1;
	localparam logic [4:0] RT_BLTZAL  = 5'd16;
	localparam logic [4:0] RT_BGEZAL  = 5'd17;
	localparam logic [4:0] LINK_REG   = 5'd31;

	localparam int MD_STEPS = 32;

endpackage

// ===== rtl/core/iieu_regfile.sv =====
// ----------------------------------------------------------------------------
// iieu_regfile
// 32 x 32 register memory, one write port, two registered read ports
// ----------------------------------------------------------------------------
module iieu_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  ra_addr,
	input  logic [4:0]  rb_addr,
	output logic [31:0] ra_data,
	output logic [31:0] rb_data,
	input  logic        wr_en,
	input  logic [4:0]  wr_addr,
	input  logic [31:0] wr_data
);

	logic [31:0] mem [32];
	logic [31:0] valid_q;
	logic [31:0] ra_q;
	logic [31:0] rb_q;
	logic        ra_ok_q;
	logic        rb_ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ra_q <= mem[ra_addr];
			rb_q <= mem[rb_addr];
		end
	end

	// entries not yet written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ra_ok_q <= 1'b0;
			rb_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				ra_ok_q <= valid_q[ra_addr];
				rb_ok_q <= valid_q[rb_addr];
			end
		end
	end

	assign ra_data = ra_ok_q ? ra_q : 32'd0;
	assign rb_data = rb_ok_q ? rb_q : 32'd0;

endmodule

// ===== rtl/core/iieu_muldiv.sv =====
// ----------------------------------------------------------------------------
// iieu_muldiv
// iterative multiply and divide, one bit per cycle on magnitudes
// ----------------------------------------------------------------------------
module iieu_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  iieu_pkg::md_ctl_t ctl,
	input  logic [31:0]      a,
	input  logic [31:0]      b,
	output iieu_pkg::md_rsp_t rsp,
	output logic [31:0]      hi,
	output logic [31:0]      lo
);

	logic [31:0] ma_q;
	logic [31:0] mb_q;
	logic [63:0] acc_q;
	logic        is_div_q;
	logic        negq_q;
	logic        negr_q;
	logic        run_q;
	logic        fin_q;
	logic        done_q;
	logic        skip_q;
	logic [5:0]  cnt_q;

	logic [31:0] ma;
	logic [31:0] mb;
	logic [32:0] msum;
	logic [32:0] r33;
	logic [33:0] diff;

	assign ma   = (ctl.sgn && a[31]) ? (32'd0 - a) : a;
	assign mb   = (ctl.sgn && b[31]) ? (32'd0 - b) : b;
	assign msum = {1'b0, acc_q[63:32]} + {1'b0, ma_q};
	assign r33  = acc_q[63:31];
	assign diff = {1'b0, r33} - {2'b00, mb_q};

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			ma_q     <= ma;
			mb_q     <= mb;
			acc_q    <= ctl.is_div ? {32'd0, ma} : {32'd0, mb};
			is_div_q <= ctl.is_div;
			negq_q   <= ctl.sgn && (a[31] ^ b[31]);
			negr_q   <= ctl.sgn && a[31];
		end else if (run_q) begin
			if (is_div_q) begin
				if (!diff[33]) begin
					acc_q <= {diff[31:0], acc_q[30:0], 1'b1};
				end else begin
					acc_q <= {r33[31:0], acc_q[30:0], 1'b0};
				end
			end else begin
				acc_q <= acc_q[0] ? {msum, acc_q[31:1]} : {1'b0, acc_q[63:1]};
			end
		end else if (fin_q) begin
			// sign fix-up
			if (is_div_q) begin
				acc_q[31:0]  <= negq_q ? (32'd0 - acc_q[31:0]) : acc_q[31:0];
				acc_q[63:32] <= negr_q ? (32'd0 - acc_q[63:32]) : acc_q[63:32];
			end else if (negq_q) begin
				acc_q <= 64'd0 - acc_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			skip_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			skip_q <= 1'b0;
			if (ctl.start) begin
				if (ctl.is_div && b == 32'd0) begin
					done_q <= 1'b1;
					skip_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= '0;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(iieu_pkg::MD_STEPS - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.skip = skip_q;
	assign hi       = acc_q[63:32];
	assign lo       = acc_q[31:0];

endmodule

// ===== rtl/core/iieu_exec.sv =====
// ----------------------------------------------------------------------------
// iieu_exec
// decode and combinational execute of one instruction word
// ----------------------------------------------------------------------------
module iieu_exec (
	input  iieu_pkg::cmd_t  cmd,
	input  logic [31:0]     a,
	input  logic [31:0]     b,
	input  logic [31:0]     pc,
	input  logic [31:0]     hi,
	input  logic [31:0]     lo,
	output iieu_pkg::res_t  res
);

	logic [31:0] ins;
	logic [5:0]  op;
	logic [5:0]  fn;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sh;
	logic [31:0] imm_z;
	logic [31:0] imm_s;
	logic [31:0] seq;
	logic [31:0] btarget;
	logic [31:0] jtarget;
	logic [31:0] sum_ab;
	logic [31:0] dif_ab;
	logic [31:0] sum_ai;
	logic        lt_s;
	logic        lt_u;
	logic        lti_s;
	logic        lti_u;
	logic        le_z;

	assign ins       = cmd.instruction;
	assign op        = ins[31:26];
	assign rt        = ins[20:16];
	assign rd        = ins[15:11];
	assign sh        = ins[10:6];
	assign fn        = ins[5:0];
	assign imm_z     = {16'd0, ins[15:0]};
	assign imm_s     = {{16{ins[15]}}, ins[15:0]};
	assign seq       = pc + 32'd4;
	assign btarget   = seq + {imm_s[29:0], 2'b00};
	assign jtarget   = {seq[31:28], ins[25:0], 2'b00};
	assign sum_ab    = a + b;
	assign dif_ab    = a - b;
	assign sum_ai    = a + imm_s;
	assign lt_s      = $signed(a) < $signed(b);
	assign lt_u      = a < b;
	assign lti_s     = $signed(a) < $signed(imm_s);
	assign lti_u     = a < imm_s;
	assign le_z      = (a == 32'd0) || a[31];

	always_comb begin
		res        = '0;
		res.status = iieu_pkg::ST_OK;
		res.npc    = seq;
		res.hi     = hi;
		res.lo     = lo;
		if (cmd.operation) begin
			res.npc = cmd.new_pc;
		end else if (op == iieu_pkg::OP_SPECIAL) begin
			res.widx = rd;
			unique case (fn)
				iieu_pkg::FN_SLL: begin res.wr = 1'b1; res.wval = b << sh; end
				iieu_pkg::FN_SRL: begin res.wr = 1'b1; res.wval = b >> sh; end
				iieu_pkg::FN_SRA: begin
					res.wr = 1'b1; res.wval = 32'($signed(b) >>> sh);
				end
				iieu_pkg::FN_SLLV: begin res.wr = 1'b1; res.wval = b << a[4:0]; end
				iieu_pkg::FN_SRLV: begin res.wr = 1'b1; res.wval = b >> a[4:0]; end
				iieu_pkg::FN_SRAV: begin
					res.wr = 1'b1; res.wval = 32'($signed(b) >>> a[4:0]);
				end
				iieu_pkg::FN_JR:      res.npc = a;
				iieu_pkg::FN_SYSCALL: res.status = iieu_pkg::ST_SYSCALL;
				iieu_pkg::FN_MFHI: begin res.wr = 1'b1; res.wval = hi; end
				iieu_pkg::FN_MTHI:    res.hi = a;
				iieu_pkg::FN_MFLO: begin res.wr = 1'b1; res.wval = lo; end
				iieu_pkg::FN_MTLO:    res.lo = a;
				iieu_pkg::FN_MULT:  res.md = '{start: 1'b1, is_div: 1'b0, sgn: 1'b1};
				iieu_pkg::FN_MULTU: res.md = '{start: 1'b1, is_div: 1'b0, sgn: 1'b0};
				iieu_pkg::FN_DIV:   res.md = '{start: 1'b1, is_div: 1'b1, sgn: 1'b1};
				iieu_pkg::FN_DIVU:  res.md = '{start: 1'b1, is_div: 1'b1, sgn: 1'b0};
				iieu_pkg::FN_ADD: begin
					if ((a[31] == b[31]) && (sum_ab[31] != a[31])) begin
						res.status = iieu_pkg::ST_OVERFLOW;
					end else begin
						res.wr = 1'b1; res.wval = sum_ab;
					end
				end
				iieu_pkg::FN_ADDU: begin res.wr = 1'b1; res.wval = sum_ab; end
				iieu_pkg::FN_SUB: begin
					if ((a[31] != b[31]) && (dif_ab[31] != a[31])) begin
						res.status = iieu_pkg::ST_OVERFLOW;
					end else begin
						res.wr = 1'b1; res.wval = dif_ab;
					end
				end
				iieu_pkg::FN_SUBU: begin res.wr = 1'b1; res.wval = dif_ab; end
				iieu_pkg::FN_AND:  begin res.wr = 1'b1; res.wval = a & b; end
				iieu_pkg::FN_OR:   begin res.wr = 1'b1; res.wval = a | b; end
				iieu_pkg::FN_XOR:  begin res.wr = 1'b1; res.wval = a ^ b; end
				iieu_pkg::FN_NOR:  begin res.wr = 1'b1; res.wval = ~(a | b); end
				iieu_pkg::FN_SLT:  begin res.wr = 1'b1; res.wval = {31'd0, lt_s}; end
				iieu_pkg::FN_SLTU: begin res.wr = 1'b1; res.wval = {31'd0, lt_u}; end
				default: res.status = iieu_pkg::ST_INVALID;
			endcase
		end else begin
			res.widx = rt;
			unique case (op)
				iieu_pkg::OP_REGIMM: begin
					if (rt == iieu_pkg::RT_BLTZ || rt == iieu_pkg::RT_BGEZ ||
					    rt == iieu_pkg::RT_BLTZAL || rt == iieu_pkg::RT_BGEZAL) begin
						if (rt[0] ? !a[31] : a[31]) begin
							res.npc = btarget;
							if (rt[4]) begin
								res.wr   = 1'b1;
								res.widx = iieu_pkg::LINK_REG;
								res.wval = seq;
							end
						end
					end else begin
						res.status = iieu_pkg::ST_INVALID;
					end
				end
				iieu_pkg::OP_J: res.npc = jtarget;
				iieu_pkg::OP_JAL: begin
					res.npc  = jtarget;
					res.wr   = 1'b1;
					res.widx = iieu_pkg::LINK_REG;
					res.wval = seq;
				end
				iieu_pkg::OP_BEQ: if (a == b) res.npc = btarget;
				iieu_pkg::OP_BNE: if (a != b) res.npc = btarget;
				iieu_pkg::OP_BLEZ, iieu_pkg::OP_BGTZ: begin
					if (rt != 5'd0) begin
						res.status = iieu_pkg::ST_INVALID;
					end else if ((op == iieu_pkg::OP_BLEZ) ? le_z : !le_z) begin
						res.npc = btarget;
					end
				end
				iieu_pkg::OP_ADDI: begin
					if ((a[31] == imm_s[31]) && (sum_ai[31] != a[31])) begin
						res.status = iieu_pkg::ST_OVERFLOW;
					end else begin
						res.wr = 1'b1; res.wval = sum_ai;
					end
				end
				iieu_pkg::OP_ADDIU: begin res.wr = 1'b1; res.wval = sum_ai; end
				iieu_pkg::OP_SLTI:  begin res.wr = 1'b1; res.wval = {31'd0, lti_s}; end
				iieu_pkg::OP_SLTIU: begin res.wr = 1'b1; res.wval = {31'd0, lti_u}; end
				iieu_pkg::OP_ANDI:  begin res.wr = 1'b1; res.wval = a & imm_z; end
				iieu_pkg::OP_ORI:   begin res.wr = 1'b1; res.wval = a | imm_z; end
				iieu_pkg::OP_XORI:  begin res.wr = 1'b1; res.wval = a ^ imm_z; end
				iieu_pkg::OP_LUI: begin
					res.wr = 1'b1; res.wval = {ins[15:0], 16'd0};
				end
				default: res.status = iieu_pkg::ST_INVALID;
			endcase
		end
		// a faulting step changes nothing
		if (res.status != iieu_pkg::ST_OK) begin
			res.npc = pc;
			res.hi  = hi;
			res.lo  = lo;
			res.wr  = 1'b0;
			res.md  = '0;
		end
		if (!res.wr || res.widx == 5'd0) begin
			res.wr   = 1'b0;
			res.widx = 5'd0;
			res.wval = 32'd0;
		end
	end

endmodule

// ===== rtl/core/integer_instruction_execute_unit.sv =====
// ----------------------------------------------------------------------------
// integer_instruction_execute_unit
// mips-i integer execute unit around a 32-entry register memory
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | word
//  cmd     | in        | cmd_valid/stall  | cmd_t (operation, instruction, pc, probe)
//  rsp     | out       | rsp_valid/stall  | rsp_t (status, pc, write, hi, lo, probe)
//
//  alu, branch and jump ops: read on accept, execute, write back with probe read, output
//  mult/div: waits for the bit-serial unit to finish, divide by zero skips the iterations
//  reset: registers read zero via per-entry valid bits, pc/hi/lo cleared
//  one word in flight; the next word is taken as soon as the result sits in
//  the output register, even while rsp is stalled
// ----------------------------------------------------------------------------
module integer_instruction_execute_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  iieu_pkg::cmd_t   cmd,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output iieu_pkg::rsp_t   rsp
);

	iieu_pkg::fsm_t   state_q;
	iieu_pkg::fsm_t   state_nxt;
	iieu_pkg::cmd_t   cmd_q;
	iieu_pkg::res_t   res_s2;
	iieu_pkg::res_t   ex_res;
	iieu_pkg::md_ctl_t md_ctl;
	iieu_pkg::md_rsp_t md_rsp;
	iieu_pkg::rsp_t   rsp_q;

	logic [31:0] pc_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic        rsp_valid_q;
	logic        fwd_q;

	logic        accept;
	logic        rd_en;
	logic [4:0]  ra_addr;
	logic [31:0] ra_data;
	logic [31:0] rb_data;
	logic        wr_en;
	logic [31:0] md_hi;
	logic [31:0] md_lo;
	logic        out_free;

	assign accept   = cmd_valid && !cmd_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// port a reads rs on accept, the probed register during write back
	assign rd_en   = accept || (state_q == iieu_pkg::FSM_WB);
	assign ra_addr = accept ? cmd.instruction[25:21] : cmd_q.probe_index;
	assign wr_en   = (state_q == iieu_pkg::FSM_WB) && res_s2.wr;

	iieu_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.ra_addr (ra_addr),
		.rb_addr (cmd.instruction[20:16]),
		.ra_data (ra_data),
		.rb_data (rb_data),
		.wr_en   (wr_en),
		.wr_addr (res_s2.widx),
		.wr_data (res_s2.wval)
	);

	iieu_exec u_exec (
		.cmd (cmd_q),
		.a   (ra_data),
		.b   (rb_data),
		.pc  (pc_q),
		.hi  (hi_q),
		.lo  (lo_q),
		.res (ex_res)
	);

	// start pulse only in the execute cycle
	always_comb begin
		md_ctl       = ex_res.md;
		md_ctl.start = ex_res.md.start && (state_q == iieu_pkg::FSM_EXEC);
	end

	iieu_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md_ctl),
		.a      (ra_data),
		.b      (rb_data),
		.rsp    (md_rsp),
		.hi     (md_hi),
		.lo     (md_lo)
	);

	// sequencer
	always_comb begin
		state_nxt = state_q;
		cmd_stall = 1'b1;
		unique case (state_q)
			iieu_pkg::FSM_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					state_nxt = iieu_pkg::FSM_EXEC;
				end
			end
			iieu_pkg::FSM_EXEC: begin
				state_nxt = ex_res.md.start ? iieu_pkg::FSM_MD : iieu_pkg::FSM_WB;
			end
			iieu_pkg::FSM_MD: begin
				if (md_rsp.done) begin
					state_nxt = iieu_pkg::FSM_WB;
				end
			end
			iieu_pkg::FSM_WB: state_nxt = iieu_pkg::FSM_OUT;
			iieu_pkg::FSM_OUT: begin
				if (out_free) begin
					state_nxt = iieu_pkg::FSM_IDLE;
				end
			end
			default: state_nxt = iieu_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iieu_pkg::FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// payload: captured word, execute result, probe forward
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (state_q == iieu_pkg::FSM_EXEC) begin
			res_s2 <= ex_res;
		end
		if (state_q == iieu_pkg::FSM_MD && md_rsp.done && !md_rsp.skip) begin
			res_s2.hi <= md_hi;
			res_s2.lo <= md_lo;
		end
		if (state_q == iieu_pkg::FSM_WB) begin
			// probe read races the write to the same entry
			fwd_q <= res_s2.wr && (res_s2.widx == cmd_q.probe_index);
		end
		if (state_q == iieu_pkg::FSM_OUT && out_free) begin
			rsp_q.status         <= res_s2.status;
			rsp_q.pc_after       <= res_s2.npc;
			rsp_q.wrote_register <= res_s2.wr;
			rsp_q.written_index  <= res_s2.widx;
			rsp_q.written_value  <= res_s2.wval;
			rsp_q.hi_value       <= hi_q;
			rsp_q.lo_value       <= lo_q;
			rsp_q.probe_value    <= fwd_q ? res_s2.wval : ra_data;
		end
	end

	// architectural pc, hi, lo commit in write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == iieu_pkg::FSM_WB) begin
				pc_q <= res_s2.npc;
				hi_q <= res_s2.hi;
				lo_q <= res_s2.lo;
			end
			if (state_q == iieu_pkg::FSM_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives instruction words into the integer execute unit and compares every
// result word with a predictor that keeps its own register file, pc, hi, lo
// ----------------------------------------------------------------------------
module testbench;
	import iieu_pkg::*;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	integer_instruction_execute_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	localparam int IDLE_LIMIT = 20000;

	// predictor state
	logic [31:0] gpr [32];
	logic [31:0] pc_q, hi_q, lo_q;
	rsp_t result_queue [$];
	int errors;
	int idle_cycles;
	// receiver hold-off request, served by the stall process
	int hold_req;
	logic holding;

	initial begin
		clk = 1'b0;
		forever begin
			#2 clk = 1'b1;
			#2 clk = 1'b0;
		end
	end

	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// compute one expected result word and advance the predictor state
	function automatic rsp_t execute_word(cmd_t c);
		rsp_t o;
		logic [5:0] op, fn;
		logic [4:0] rs, rt, rd, sh;
		logic [31:0] a, b, seq, bt, npc, nhi, nlo, wval, r, q, m, ma, mb;
		logic [63:0] p;
		logic wr, neg, take, le;
		logic [4:0] widx;
		status_t st;
		op = c.instruction[31:26]; rs = c.instruction[25:21];
		rt = c.instruction[20:16]; rd = c.instruction[15:11];
		sh = c.instruction[10:6]; fn = c.instruction[5:0];
		a = gpr[rs]; b = gpr[rt];
		seq = pc_q + 32'd4;
		bt = seq + (sx16(c.instruction[15:0]) << 2);
		st = ST_OK; npc = seq; nhi = hi_q; nlo = lo_q;
		wr = 1'b0; widx = 5'd0; wval = 32'd0;
		if (c.operation) begin
			npc = c.new_pc;
		end else if (op == OP_SPECIAL) begin
			wr = 1'b1; widx = rd;
			case (fn)
				FN_SLL: wval = b << sh;
				FN_SRL: wval = b >> sh;
				FN_SRA: wval = $signed(b) >>> sh;
				FN_SLLV: wval = b << a[4:0];
				FN_SRLV: wval = b >> a[4:0];
				FN_SRAV: wval = $signed(b) >>> a[4:0];
				FN_JR: begin wr = 1'b0; npc = a; end
				FN_SYSCALL: st = ST_SYSCALL;
				FN_MFHI: wval = hi_q;
				FN_MTHI: begin wr = 1'b0; nhi = a; end
				FN_MFLO: wval = lo_q;
				FN_MTLO: begin wr = 1'b0; nlo = a; end
				FN_MULT: begin
					wr = 1'b0;
					p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
					nhi = p[63:32]; nlo = p[31:0];
				end
				FN_MULTU: begin
					wr = 1'b0; p = {32'd0, a} * {32'd0, b};
					nhi = p[63:32]; nlo = p[31:0];
				end
				FN_DIV: begin
					wr = 1'b0;
					if (b != 0) begin
						ma = a[31] ? -a : a; mb = b[31] ? -b : b;
						q = ma / mb; m = ma % mb;
						if (a[31] ^ b[31]) q = -q;
						if (a[31]) m = -m;
						nlo = q; nhi = m;
					end
				end
				FN_DIVU: begin
					wr = 1'b0;
					if (b != 0) begin nlo = a / b; nhi = a % b; end
				end
				FN_ADD: begin
					r = a + b; wval = r;
					if ((a ^ r) & (b ^ r) & 32'h8000_0000) st = ST_OVERFLOW;
				end
				FN_ADDU: wval = a + b;
				FN_SUB: begin
					r = a - b; wval = r;
					if ((a ^ b) & (a ^ r) & 32'h8000_0000) st = ST_OVERFLOW;
				end
				FN_SUBU: wval = a - b;
				FN_AND: wval = a & b;
				FN_OR: wval = a | b;
				FN_XOR: wval = a ^ b;
				FN_NOR: wval = ~(a | b);
				FN_SLT: wval = {31'd0, $signed(a) < $signed(b)};
				FN_SLTU: wval = {31'd0, a < b};
				default: st = ST_INVALID;
			endcase
		end else begin
			case (op)
				OP_REGIMM: begin
					if (rt == RT_BLTZ || rt == RT_BGEZ || rt == RT_BLTZAL || rt == RT_BGEZAL) begin
						neg = a[31];
						take = rt[0] ? !neg : neg;
						if (take) begin
							npc = bt;
							if (rt[4]) begin wr = 1'b1; widx = LINK_REG; wval = seq; end
						end
					end else st = ST_INVALID;
				end
				OP_J: npc = {seq[31:28], c.instruction[25:0], 2'b00};
				OP_JAL: begin
					npc = {seq[31:28], c.instruction[25:0], 2'b00};
					wr = 1'b1; widx = LINK_REG; wval = seq;
				end
				OP_BEQ: if (a == b) npc = bt;
				OP_BNE: if (a != b) npc = bt;
				OP_BLEZ, OP_BGTZ: begin
					if (rt != 0) st = ST_INVALID;
					else begin
						le = (a == 0) || a[31];
						if ((op == OP_BLEZ) ? le : !le) npc = bt;
					end
				end
				OP_ADDI: begin
					r = a + sx16(c.instruction[15:0]);
					if ((a ^ r) & (sx16(c.instruction[15:0]) ^ r) & 32'h8000_0000)
						st = ST_OVERFLOW;
					else begin wr = 1'b1; widx = rt; wval = r; end
				end
				OP_ADDIU: begin wr = 1'b1; widx = rt; wval = a + sx16(c.instruction[15:0]); end
				OP_SLTI: begin
					wr = 1'b1; widx = rt;
					wval = {31'd0, $signed(a) < $signed(sx16(c.instruction[15:0]))};
				end
				OP_SLTIU: begin
					wr = 1'b1; widx = rt; wval = {31'd0, a < sx16(c.instruction[15:0])};
				end
				OP_ANDI: begin wr = 1'b1; widx = rt; wval = a & {16'd0, c.instruction[15:0]}; end
				OP_ORI: begin wr = 1'b1; widx = rt; wval = a | {16'd0, c.instruction[15:0]}; end
				OP_XORI: begin wr = 1'b1; widx = rt; wval = a ^ {16'd0, c.instruction[15:0]}; end
				OP_LUI: begin wr = 1'b1; widx = rt; wval = {c.instruction[15:0], 16'd0}; end
				default: st = ST_INVALID;
			endcase
		end
		// a failing step leaves everything as it was
		if (st != ST_OK) begin
			npc = pc_q; nhi = hi_q; nlo = lo_q; wr = 1'b0;
		end
		if (!wr || widx == 0) begin
			wr = 1'b0; widx = 5'd0; wval = 32'd0;
		end else begin
			gpr[widx] = wval;
		end
		pc_q = npc; hi_q = nhi; lo_q = nlo;
		o.status = st; o.pc_after = npc; o.wrote_register = wr;
		o.written_index = widx; o.written_value = wval;
		o.hi_value = hi_q; o.lo_value = lo_q;
		o.probe_value = (c.probe_index == 0) ? 32'd0 : gpr[c.probe_index];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	// sender: offers a word at the falling edge, holds it until accepted
	task automatic send_word(cmd_t c);
		@(negedge clk);
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		result_queue.push_back(execute_word(c));
	endtask

	// random gap after a burst, only between words
	int burst_left;
	task automatic maybe_gap();
		int g;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 12);
		g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (g > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic issue(cmd_t c);
		maybe_gap();
		send_word(c);
	endtask

	function automatic cmd_t mk(logic [31:0] ins, logic [4:0] probe);
		cmd_t c;
		c.operation = 1'b0; c.instruction = ins;
		c.new_pc = $urandom; c.probe_index = probe;
		return c;
	endfunction

	function automatic logic [31:0] r_type(logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] sh, logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs,
			logic [4:0] rt, logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	task automatic load_pc(logic [31:0] v);
		cmd_t c;
		c.operation = 1'b1; c.instruction = $urandom; c.new_pc = v;
		c.probe_index = 5'($urandom);
		issue(c);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (result_queue.size() != 0) @(posedge clk);
	endtask

	// directed: extremes, overflow, syscall, invalid codes, divide corners
	task automatic test_directed();
		load_pc(32'hFFFF_FFF8);
		issue(mk(i_type(OP_LUI, 5'd0, 5'd1, 16'h8000), 5'd1));
		issue(mk(i_type(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF), 5'd2));
		issue(mk(i_type(OP_ORI, 5'd0, 5'd3, 16'hFFFF), 5'd3));
		issue(mk(r_type(5'd1, 5'd2, 5'd4, 5'd0, FN_ADD), 5'd4));
		issue(mk(r_type(5'd1, 5'd3, 5'd5, 5'd0, FN_SUB), 5'd5));
		issue(mk(i_type(OP_ADDI, 5'd1, 5'd6, 16'hFFFF), 5'd6));
		issue(mk(r_type(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL), 5'd0));
		issue(mk({6'd35, 26'h0}, 5'd1));
		issue(mk(r_type(5'd0, 5'd0, 5'd0, 5'd0, 6'd13), 5'd1));
		issue(mk(i_type(OP_REGIMM, 5'd1, 5'd2, 16'h0), 5'd1));
		issue(mk(i_type(OP_BLEZ, 5'd1, 5'd1, 16'h0), 5'd1));
		issue(mk(r_type(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV), 5'd0));
		issue(mk(r_type(5'd1, 5'd0, 5'd0, 5'd0, FN_DIVU), 5'd0));
		issue(mk(r_type(5'd2, 5'd3, 5'd0, 5'd0, FN_DIV), 5'd0));
		issue(mk(r_type(5'd2, 5'd2, 5'd0, 5'd0, FN_MULTU), 5'd0));
		issue(mk(r_type(5'd0, 5'd2, 5'd7, 5'd31, FN_SRA), 5'd7));
		issue(mk(r_type(5'd2, 5'd1, 5'd0, 5'd0, FN_ADDU), 5'd0));
		issue(mk({OP_JAL, 26'h3FF_FFFF}, 5'd31));
		issue(mk(i_type(OP_REGIMM, 5'd1, RT_BLTZAL, 16'h8000), 5'd31));
		issue(mk(r_type(5'd2, 5'd0, 5'd0, 5'd0, FN_JR), 5'd2));
		issue(mk(r_type(5'd0, 5'd0, 5'd8, 5'd0, FN_MFHI), 5'd8));
		issue(mk(r_type(5'd0, 5'd0, 5'd9, 5'd0, FN_MFLO), 5'd9));
		wait_drained();
	endtask

	function automatic logic [5:0] pick_fn();
		logic [5:0] fns [26] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
			FN_JR, FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU,
			FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
			FN_NOR, FN_SLT, FN_SLTU};
		return fns[$urandom_range(0, 25)];
	endfunction

	// random: mostly defined instructions, small register subset, some noise
	task automatic test_random(int n);
		logic [31:0] ins;
		logic [4:0] rs, rt, rd;
		logic [4:0] rts [4] = '{RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL};
		int k;
		for (int i = 0; i < n; i++) begin
			rs = 5'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7));
			rt = 5'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7));
			rd = 5'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7));
			k = $urandom_range(0, 19);
			if (k < 9) ins = {OP_SPECIAL, rs, rt, rd, 5'($urandom), pick_fn()};
			else if (k < 15) ins = {6'($urandom_range(8, 15)), rs, rt, 16'($urandom)};
			else if (k < 17) ins = {6'($urandom_range(2, 7)), rs,
				($urandom_range(0, 3) == 0) ? rt : 5'd0, 16'($urandom)};
			else if (k < 18) ins = {OP_REGIMM, rs, rts[$urandom_range(0, 3)], 16'($urandom)};
			else ins = $urandom;
			if ($urandom_range(0, 40) == 0) load_pc($urandom);
			else issue(mk(ins, 5'($urandom)));
		end
	endtask

	// receiver goes quiet while the sender keeps offering words
	task automatic test_backpressure();
		hold_req = 300;
		test_random(12);
		wait_drained();
	endtask

	// receiver stall pattern, plus the long hold-off
	initial begin
		int mode;
		rsp_stall = 1'b0;
		holding = 1'b0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				holding = 1'b1;
				rsp_stall <= 1'b1;
				repeat (hold_req) @(negedge clk);
				hold_req = 0;
				holding = 1'b0;
			end
			if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
			case (mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 2) == 0);
				default: rsp_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// result checker
	initial begin
		rsp_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (result_queue.size() == 0) begin
					report_mismatch("unexpected word pc_after", rsp.pc_after, 32'd0);
				end else begin
					want = result_queue.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.pc_after !== want.pc_after)
						report_mismatch("pc_after", rsp.pc_after, want.pc_after);
					if (rsp.wrote_register !== want.wrote_register)
						report_mismatch("wrote_register", rsp.wrote_register,
							want.wrote_register);
					if (rsp.written_index !== want.written_index)
						report_mismatch("written_index", rsp.written_index,
							want.written_index);
					if (rsp.written_value !== want.written_value)
						report_mismatch("written_value", rsp.written_value,
							want.written_value);
					if (rsp.hi_value !== want.hi_value)
						report_mismatch("hi_value", rsp.hi_value, want.hi_value);
					if (rsp.lo_value !== want.lo_value)
						report_mismatch("lo_value", rsp.lo_value, want.lo_value);
					if (rsp.probe_value !== want.probe_value)
						report_mismatch("probe_value", rsp.probe_value, want.probe_value);
				end
			end
		end
	end

	// watchdog: cycles with no accepted word on either channel
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || holding)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		hold_req = 0;
		burst_left = 0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		for (int i = 0; i < 32; i++) gpr[i] = 32'd0;
		pc_q = 32'd0; hi_q = 32'd0; lo_q = 32'd0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random(430);
		wait_drained();
		// trailing window for stray result words
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
